// File: sv/rks_pkg.sv
// ----------------------------------------------------------------------------
// rks_pkg - shared types and constants for range_kth_smallest
// Opcodes, status codes, microprogram step codes, jump conditions, the
// control word and the microcode table.
// ----------------------------------------------------------------------------
package rks_pkg;

	// item kinds (s_axis_tuser)
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result status (m_axis_tuser)
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [1:0] ST_BAD_RANK  = 2'd2;

	// field widths
	localparam int VAL_W  = 32;
	localparam int WIDX_W = 7;
	localparam int POS_W  = 8;
	localparam int CNT_POS_W = POS_W + 1;  // position counter, may reach last+1

	// microprogram steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_WAIT  = 4'd0;
	localparam logic [STEP_W-1:0] S_CHECK = 4'd1;
	localparam logic [STEP_W-1:0] S_RDI   = 4'd2;
	localparam logic [STEP_W-1:0] S_KEY   = 4'd3;
	localparam logic [STEP_W-1:0] S_SCAN  = 4'd4;
	localparam logic [STEP_W-1:0] S_TEST  = 4'd5;
	localparam logic [STEP_W-1:0] S_NEXT  = 4'd6;
	localparam logic [STEP_W-1:0] S_EMIT  = 4'd7;
	localparam logic [STEP_W-1:0] S_DONE  = 4'd8;

	// jump conditions
	localparam logic [2:0] C_NEVER  = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_IDLE   = 3'd2;  // no query taken this cycle
	localparam logic [2:0] C_BAD    = 3'd3;
	localparam logic [2:0] C_MORE_J = 3'd4;
	localparam logic [2:0] C_HIT    = 3'd5;
	localparam logic [2:0] C_BUSY   = 3'd6;

	typedef struct packed {
		logic              i_init;  // candidate index <= first
		logic              j_init;  // scan index <= first, clear counts
		logic              rd_i;    // read address from candidate index
		logic              re;      // store read enable
		logic              key_ld;  // latch candidate value
		logic              j_inc;
		logic              acc;     // compare read data against candidate
		logic              chk;     // latch range / rank status
		logic              take;    // latch candidate as result on hit
		logic              i_inc;
		logic              emit;    // push result to output register
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic query_acc;
		logic bad;
		logic j_done;
		logic hit;
		logic busy;
	} flags_t;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t w;
		w = '0;
		unique case (step)
			S_WAIT: begin
				w.cond = C_IDLE;    w.target = S_WAIT;
			end
			S_CHECK: begin
				w.chk = 1'b1;       w.i_init = 1'b1;
				w.cond = C_BAD;     w.target = S_EMIT;
			end
			S_RDI: begin
				w.rd_i = 1'b1;      w.re = 1'b1;     w.j_init = 1'b1;
				w.cond = C_NEVER;   w.target = S_WAIT;
			end
			S_KEY: begin
				w.key_ld = 1'b1;    w.re = 1'b1;     w.j_inc = 1'b1;
				w.cond = C_NEVER;   w.target = S_WAIT;
			end
			S_SCAN: begin
				w.acc = 1'b1;       w.re = 1'b1;     w.j_inc = 1'b1;
				w.cond = C_MORE_J;  w.target = S_SCAN;
			end
			S_TEST: begin
				w.take = 1'b1;
				w.cond = C_HIT;     w.target = S_EMIT;
			end
			S_NEXT: begin
				w.i_inc = 1'b1;
				w.cond = C_ALWAYS;  w.target = S_RDI;
			end
			S_EMIT: begin
				w.emit = 1'b1;
				w.cond = C_BUSY;    w.target = S_EMIT;
			end
			S_DONE: begin
				w.cond = C_ALWAYS;  w.target = S_WAIT;
			end
			default: begin
				w.cond = C_ALWAYS;  w.target = S_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/rks_seq.sv
// ----------------------------------------------------------------------------
// rks_seq - microprogram sequencer
// Step counter, microcode lookup and conditional jump.
// ----------------------------------------------------------------------------
module rks_seq
	import rks_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  flags_t            flags,
	output ctl_t              ctl,
	output logic [STEP_W-1:0] step
);

	logic [STEP_W-1:0] pc_q;
	logic              jump;

	assign ctl  = ucode(pc_q);
	assign step = pc_q;

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:  jump = 1'b0;
			C_ALWAYS: jump = 1'b1;
			C_IDLE:   jump = !flags.query_acc;
			C_BAD:    jump = flags.bad;
			C_MORE_J: jump = !flags.j_done;
			C_HIT:    jump = flags.hit;
			C_BUSY:   jump = flags.busy;
			default:  jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else begin
			pc_q <= jump ? ctl.target : pc_q + STEP_W'(1);
		end
	end

endmodule

// File: sv/range_kth_smallest.sv
// ----------------------------------------------------------------------------
// range_kth_smallest - k-th smallest element of a stored range
// Element store with load and order-statistic query, run by a microcode
// sequencer over one read port of the store.
// ----------------------------------------------------------------------------
// The block holds ARRAY_DEPTH signed 32-bit elements. A load item (tuser = 0)
// writes write_value at write_index and gives no result; loads at an index
// past the store are dropped. A query item (tuser = 1) gives a one-based
// inclusive range [range_first, range_last] and a one-based rank and gives
// one result item: the rank-th smallest element of the range, duplicates
// counted separately, as if the range were sorted. A bad range (zero index,
// first after last, last past the store) returns status 1, a rank of zero or
// past the range size returns status 2, both with value zero. Entries must be
// loaded before a query reads them. A query over n = last - first + 1
// elements tests candidates in index order, and every element of the range
// is read once per candidate through the single read port of the store.
// Error results skip the candidate scan and go straight to the output stage.
// Input is taken only while the sequencer waits, but it waits with a result
// still held in the output register, so downstream stalls cost nothing
// until the next result is ready.
// ----------------------------------------------------------------------------
module range_kth_smallest
	import rks_pkg::*;
#(
	parameter int ARRAY_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [6:0] write_index, [38:7] write_value, [46:39] range_first,
	// [54:47] range_last, [62:55] rank, [63] zero
	input  logic [63:0] s_axis_tdata,
	// [0] op
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] selected_value
	output logic [31:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]  m_axis_tuser
);

	localparam int AW    = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
	localparam int CNT_W = $clog2(ARRAY_DEPTH + 1);
	localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [31:0] DEPTH_L = 32'(ARRAY_DEPTH);

	// input fields
	logic [WIDX_W-1:0]       write_index;
	logic signed [VAL_W-1:0] write_value;
	logic [POS_W-1:0]        range_first;
	logic [POS_W-1:0]        range_last;
	logic [POS_W-1:0]        rank;

	assign write_index = s_axis_tdata[6:0];
	assign write_value = s_axis_tdata[38:7];
	assign range_first = s_axis_tdata[46:39];
	assign range_last  = s_axis_tdata[54:47];
	assign rank        = s_axis_tdata[62:55];

	ctl_t              ctl;
	flags_t            flags;
	logic [STEP_W-1:0] step;

	logic in_acc, load_we;

	// query registers
	logic [POS_W-1:0]     first_q, last_q, rank_q;
	logic [POS_W-1:0]     lo, hi;
	logic [CNT_POS_W-1:0] i_q, j_q;
	logic [CNT_W-1:0]     less_q, eq_q;
	logic signed [VAL_W-1:0] key_q, rdata_q;
	logic signed [VAL_W-1:0] res_val_q;
	logic [1:0]              res_stat_q;
	logic bad_range, bad_rank, hit;

	// output register
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic [1:0]              out_stat_q;

	// element store
	logic signed [VAL_W-1:0] mem [ARRAY_DEPTH];
	logic [AW-1:0]           raddr;
	logic                    rd_en;

	assign s_axis_tready = (step == S_WAIT);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_we       = in_acc && (s_axis_tuser == OP_LOAD)
	                       && (32'(write_index) < DEPTH_L);

	// zero-based bounds of the range
	assign lo = first_q - POS_W'(1);
	assign hi = last_q - POS_W'(1);

	assign bad_range = (first_q == '0) || (last_q == '0) || (first_q > last_q)
	                   || (32'(last_q) > DEPTH_L);
	// rank > last - first + 1, rearranged to stay unsigned
	assign bad_rank  = (rank_q == '0) ||
	                   (({1'b0, rank_q} + {1'b0, first_q}) > ({1'b0, last_q} + 9'd1));

	// candidate covers the rank when less < rank <= less + equal
	assign hit = (CW'(less_q) < CW'(rank_q)) &&
	             (CW'(rank_q) <= CW'(less_q) + CW'(eq_q));

	assign flags.query_acc = in_acc && (s_axis_tuser == OP_QUERY);
	assign flags.bad       = bad_range || bad_rank;
	assign flags.j_done    = (j_q == ({1'b0, hi} + CNT_POS_W'(1)));
	assign flags.hit       = hit;
	assign flags.busy      = out_valid_q && !m_axis_tready;

	rks_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.step   (step)
	);

	// one read per cycle: candidate or scan element
	assign raddr = ctl.rd_i ? AW'(i_q) : AW'(j_q);
	assign rd_en = ctl.re && (ctl.rd_i || (j_q <= {1'b0, hi}));

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[AW'(write_index)] <= write_value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_q <= range_first;
			last_q  <= range_last;
			rank_q  <= rank;
		end
		if (ctl.i_init) begin
			i_q <= {1'b0, lo};
		end else if (ctl.i_inc) begin
			i_q <= i_q + CNT_POS_W'(1);
		end
		if (ctl.j_init) begin
			j_q    <= {1'b0, lo};
			less_q <= '0;
			eq_q   <= '0;
		end else begin
			if (ctl.j_inc) begin
				j_q <= j_q + CNT_POS_W'(1);
			end
			if (ctl.acc) begin
				if (rdata_q < key_q) begin
					less_q <= less_q + CNT_W'(1);
				end else if (rdata_q == key_q) begin
					eq_q <= eq_q + CNT_W'(1);
				end
			end
		end
		if (ctl.key_ld) begin
			key_q <= rdata_q;
		end
		if (ctl.chk) begin
			res_val_q <= '0;
			priority if (bad_range) begin
				res_stat_q <= ST_BAD_RANGE;
			end else if (bad_rank) begin
				res_stat_q <= ST_BAD_RANK;
			end else begin
				res_stat_q <= ST_OK;
			end
		end else if (ctl.take && hit) begin
			res_val_q <= key_q;
		end
	end

	// output register, refilled once the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && !flags.busy) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && !flags.busy) begin
			out_val_q  <= res_val_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_stat_q;

	// checks

	// a query item starts the range check on the next cycle
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY))
		|=> (step == S_CHECK))
		else $error("query not followed by range check");

	// the scan pointer never runs past one beyond the range end
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step == S_SCAN) |-> (j_q <= ({1'b0, hi} + CNT_POS_W'(1))))
		else $error("scan index past range end");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
		else $error("error result with nonzero value");

	// a candidate test is reached only for a valid range and rank
	a_test_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(step == S_TEST) |-> (!bad_range && !bad_rank && (res_stat_q == ST_OK)))
		else $error("candidate test on a bad query");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for range_kth_smallest
// Loads elements and queries order statistics over ranges through the input
// stream. A mirror of the element store predicts every query answer at the
// moment the item is taken, and each answer from the block is compared field
// by field with the oldest prediction. The sender runs in bursts with gaps
// and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top
	import rks_pkg::*;
();

	localparam int DEPTH     = 128;
	localparam int FILL      = 40;   // entries 0..FILL-1 are written early
	localparam int MAX_GAP   = 12;
	localparam int MAX_BURST = 16;
	localparam int MAX_STALL = 20;

	typedef struct {
		logic              op;
		logic [WIDX_W-1:0] widx;
		logic [VAL_W-1:0]  wval;
		logic [POS_W-1:0]  rng_first;
		logic [POS_W-1:0]  rng_last;
		logic [POS_W-1:0]  rnk;
		bit                hold_until_idle;  // sender waits for all answers first
	} cmd_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic [1:0]       status;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tuser = OP_LOAD;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	cmd_t    cmd_q[$];      // items not yet taken by the block
	answer_t answer_q[$];   // predicted answers, oldest first
	logic signed [VAL_W-1:0] mirror_store [DEPTH];

	int cycles = 0;
	int run_limit = 2_000_000;
	int cost_sum = 0;
	int mismatches = 0;
	int shown_cnt = 0;      // items put on the bus
	int taken_cnt = 0;      // items accepted
	int gap_left = 0;
	int burst_left = 1;
	int stall_left = 0;
	int stall_mode = 0;
	cmd_t    acc_cmd;
	answer_t got_ans;

	range_kth_smallest #(.ARRAY_DEPTH(DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// rank-th smallest over the one-based range of the mirror, duplicates
	// holding their own ranks
	function automatic answer_t kth_of_range(input logic [POS_W-1:0] f,
			input logic [POS_W-1:0] l, input logic [POS_W-1:0] r);
		answer_t a;
		int n;
		int less;
		int same;
		a.value = '0;
		a.status = ST_OK;
		if (f == 0 || l == 0 || f > l || l > DEPTH) begin
			a.status = ST_BAD_RANGE;
			return a;
		end
		n = int'(l) - int'(f) + 1;
		if (r == 0 || int'(r) > n) begin
			a.status = ST_BAD_RANK;
			return a;
		end
		for (int i = int'(f) - 1; i <= int'(l) - 1; i++) begin
			less = 0;
			same = 0;
			for (int j = int'(f) - 1; j <= int'(l) - 1; j++) begin
				if (mirror_store[j] < mirror_store[i])
					less++;
				else if (mirror_store[j] == mirror_store[i])
					same++;
			end
			if (less < int'(r) && int'(r) <= less + same) begin
				a.value = mirror_store[i];
				return a;
			end
		end
		// no candidate covers the rank
		a.status = ST_BAD_RANK;
		return a;
	endfunction

	// element values: full random, a narrow band for duplicates, extremes
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			1: return $urandom_range(0, 8) - 32'd4;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// unused fields of each item carry noise the block must ignore
	task automatic add_load(input int idx, input logic [VAL_W-1:0] val);
		cmd_t c;
		c.op = OP_LOAD;
		c.widx = idx[WIDX_W-1:0];
		c.wval = val;
		c.rng_first = POS_W'($urandom);
		c.rng_last = POS_W'($urandom);
		c.rnk = POS_W'($urandom);
		c.hold_until_idle = 1'b0;
		cmd_q = {cmd_q, c};
		cost_sum += 8 + MAX_GAP + MAX_STALL;
	endtask

	task automatic add_query(input int f, input int l, input int r, input bit hold);
		cmd_t c;
		int n;
		c.op = OP_QUERY;
		c.widx = WIDX_W'($urandom);
		c.wval = $urandom;
		c.rng_first = f[POS_W-1:0];
		c.rng_last = l[POS_W-1:0];
		c.rnk = r[POS_W-1:0];
		c.hold_until_idle = hold;
		cmd_q = {cmd_q, c};
		// worst case: every candidate scanned before the answer
		n = (f >= 1 && l >= f && l <= DEPTH) ? l - f + 1 : 0;
		cost_sum += n * (n + 4) + 8 + MAX_GAP + MAX_STALL;
	endtask

	// sender: takes an item at the edge where tvalid and tready are high
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			acc_cmd = cmd_q.pop_front();
			taken_cnt++;
			if (acc_cmd.op == OP_LOAD)
				mirror_store[acc_cmd.widx] = acc_cmd.wval;
			else
				answer_q = {answer_q, kth_of_range(acc_cmd.rng_first,
					acc_cmd.rng_last, acc_cmd.rnk)};
		end
	end

	// sender: bursts of items with random gaps, driven at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && taken_cnt != shown_cnt)) begin
			if (gap_left > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_q.size() > 0 &&
					!(cmd_q[0].hold_until_idle && answer_q.size() > 0)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= cmd_q[0].op;
				s_axis_tdata <= {1'b0, cmd_q[0].rnk, cmd_q[0].rng_last,
					cmd_q[0].rng_first, cmd_q[0].wval, cmd_q[0].widx};
				shown_cnt <= shown_cnt + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, MAX_BURST);
					// some bursts run straight into the next one
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 :
						$urandom_range(1, MAX_GAP);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches among always ready, short and long stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (stall_mode == 1 && $urandom_range(0, 3) == 0)
				stall_left <= $urandom_range(1, 4);
			else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
				stall_left <= $urandom_range(5, MAX_STALL);
		end
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(0, 2);
	end

	// monitor: compare each answer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected answer value %0d status %0d", $time,
					$signed(m_axis_tdata), m_axis_tuser);
				mismatches++;
			end else begin
				got_ans = answer_q.pop_front();
				if (m_axis_tdata !== got_ans.value) begin
					$display("%0t: selected_value expected %0d got %0d", $time,
						$signed(got_ans.value), $signed(m_axis_tdata));
					mismatches++;
				end
				if (m_axis_tuser !== got_ans.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						got_ans.status, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > run_limit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		int n;
		int f;

		// directed: extremes, duplicates, single element, last entry
		add_load(0, 32'h8000_0000);
		add_load(1, 32'h7fff_ffff);
		add_load(2, 32'hffff_ffff);
		add_load(3, 32'h0000_0000);
		add_load(4, 32'd5);
		add_load(5, 32'd5);
		add_load(6, 32'd1);
		add_load(7, 32'hffff_ffff);
		add_load(127, 32'd42);
		add_query(1, 8, 1, 1'b0);
		add_query(1, 8, 8, 1'b0);
		add_query(1, 8, 4, 1'b0);
		add_query(4, 4, 1, 1'b0);
		add_query(5, 6, 2, 1'b0);
		add_query(128, 128, 1, 1'b1);
		// bad ranges: zero index, first after last, last past the store
		add_query(0, 5, 1, 1'b0);
		add_query(3, 0, 1, 1'b0);
		add_query(6, 2, 1, 1'b0);
		add_query(1, 129, 1, 1'b0);
		add_query(255, 255, 255, 1'b0);
		// bad ranks: zero, one past the size, far past
		add_query(1, 8, 0, 1'b0);
		add_query(1, 8, 9, 1'b0);
		add_query(2, 3, 255, 1'b0);

		// fill the low part of the store, then query it end to end
		for (int i = 8; i < FILL; i++)
			add_load(i, pick_value());
		add_query(1, FILL, 1, 1'b1);
		add_query(1, FILL, FILL, 1'b0);

		// random mix; good queries stay inside the written low part
		for (int k = 0; k < 45; k++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				add_load($urandom_range(0, DEPTH - 1), pick_value());
			end else if (r < 80) begin
				if ($urandom_range(0, 19) == 0) begin
					f = $urandom_range(1, 4);
					n = $urandom_range(FILL - 3, FILL) - f + 1;
				end else begin
					n = $urandom_range(1, 16);
					f = $urandom_range(1, FILL + 1 - n);
				end
				add_query(f, f + n - 1, $urandom_range(1, n), $urandom_range(0, 19) == 0);
			end else if (r < 90) begin
				case ($urandom_range(0, 3))
					0: add_query(0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
					1: add_query($urandom_range(1, DEPTH), 0, $urandom_range(1, 8), 1'b0);
					2: add_query($urandom_range(2, DEPTH), 1, 1, 1'b0);
					default: add_query($urandom_range(1, 255), $urandom_range(DEPTH + 1, 255),
						$urandom_range(0, 255), 1'b0);
				endcase
			end else begin
				n = $urandom_range(1, 16);
				f = $urandom_range(1, DEPTH + 1 - n);
				add_query(f, f + n - 1, ($urandom_range(0, 2) == 0) ? 0 :
					$urandom_range(n + 1, 255), 1'b0);
			end
		end

		run_limit = 4 * cost_sum + 20_000;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (cmd_q.size() > 0 || answer_q.size() > 0)
			@(posedge clk);
		// catch any stray answer
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/rks_pkg.sv
sv/rks_seq.sv
sv/range_kth_smallest.sv
tb/sv/tb_top.sv
